[rtl/fct_pkg.sv]
// Shared types and constants for the fault code table.
package fct_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int SLOT_W      = 8;
  localparam int CODE_W      = 16;
  localparam int REPORT_W    = 5;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CLEAR = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [CODE_W-1:0] code;
    logic              match;
    logic              full;
    logic [SLOT_W-1:0] slot;
  } token_t;

endpackage

[rtl/fct_cell.sv]
// One table slot: stored code, active mark, and one stage of the query chain.
module fct_cell #(
  parameter int INDEX = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  fct_pkg::token_t tok_in,
  output fct_pkg::token_t tok_out
);

  logic [fct_pkg::CODE_W-1:0] code;
  logic                       active;
  logic                       hit;
  logic                       take;

  assign hit  = tok_in.valid && (tok_in.op == fct_pkg::OP_ADD) && active
                && (code == tok_in.code);
  assign take = tok_in.valid && (tok_in.op == fct_pkg::OP_ADD) && !tok_in.full
                && !tok_in.match && (tok_in.slot == fct_pkg::SLOT_W'(INDEX));

  always_ff @(posedge clk) begin
    if (take) begin
      code <= tok_in.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (tok_in.valid && (tok_in.op == fct_pkg::OP_CLEAR)) begin
      active <= 1'b0;
    end else if (take) begin
      active <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.op    <= tok_in.op;
    tok_out.code  <= tok_in.code;
    tok_out.match <= tok_in.match | hit;
    tok_out.full  <= tok_in.full;
    tok_out.slot  <= tok_in.slot;
  end

endmodule

[rtl/fault_code_table_top.sv]
// Top level of the fault code table: query chain, counters and output stage.
//
// Input words arrive on s_axis: tuser[0] is the opcode (0 add, 1 clear),
// tdata[15:0] the fault code. Each accepted word yields exactly one output
// word on m_axis: tuser[1:0] status (0 added, 1 full, 2 duplicate,
// 3 cleared), tdata[4:0] active count, tdata[9:5] fill count, both
// saturating at 31.
// A word walks a row of ENTRIES slot cells, one cell per cycle; each cell
// compares its stored code, and the slot at the fill pointer takes the code
// if no active match was seen upstream. A clear drops each mark in passing.
// One word is in flight at a time; its result passes down the cell row into
// a holding register, then into the output register once that register is
// free. The input reopens as the result enters the output register.
// A new word is taken as soon as the previous result reaches the output
// register, even while the receiver stalls it there; the output holds until
// m_axis_tready. Reset empties the table, zeroes both counts and drops any
// word in flight.
module fault_code_table_top #(
  parameter int ENTRIES = fct_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // [15:0] fault_code
  input  logic [0:0]  s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // [4:0] live entries, [9:5] fill_count, [15:10] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  localparam int CNT_W = $clog2(ENTRIES + 1);

  fct_pkg::token_t             tok [ENTRIES+1];
  logic                        busy;
  logic [CNT_W-1:0]            slots_used;
  logic [CNT_W-1:0]            active_total;
  logic [CNT_W-1:0]            slots_used_next;
  logic [CNT_W-1:0]            active_total_next;
  fct_pkg::status_t            status_next;
  logic                        pend_valid;
  fct_pkg::status_t            pend_status;
  logic [CNT_W-1:0]            pend_active;
  logic [CNT_W-1:0]            pend_fill;
  logic                        in_acc;
  logic                        move;
  logic [ENTRIES:0]            chain_valid;
  logic [31:0]                 active_ext;
  logic [31:0]                 fill_ext;
  logic [fct_pkg::REPORT_W-1:0] active_rep;
  logic [fct_pkg::REPORT_W-1:0] fill_rep;

  assign s_axis_tready = !busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign move          = pend_valid && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    tok[0].valid = in_acc;
    tok[0].op    = fct_pkg::op_t'(s_axis_tuser[0]);
    tok[0].code  = s_axis_tdata;
    tok[0].match = 1'b0;
    tok[0].full  = (slots_used == CNT_W'(ENTRIES));
    tok[0].slot  = fct_pkg::SLOT_W'(slots_used);
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    fct_cell #(.INDEX(i)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .tok_in (tok[i]),
      .tok_out(tok[i+1])
    );
  end

  always_comb begin
    slots_used_next   = slots_used;
    active_total_next = active_total;
    if (tok[ENTRIES].op == fct_pkg::OP_CLEAR) begin
      status_next       = fct_pkg::ST_CLEARED;
      active_total_next = '0;
    end else if (tok[ENTRIES].full) begin
      status_next = fct_pkg::ST_FULL;
    end else if (tok[ENTRIES].match) begin
      status_next = fct_pkg::ST_DUP;
    end else begin
      status_next       = fct_pkg::ST_ADDED;
      slots_used_next   = slots_used + CNT_W'(1);
      active_total_next = active_total + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      slots_used   <= '0;
      active_total <= '0;
      pend_valid   <= 1'b0;
    end else begin
      if (in_acc) begin
        busy <= 1'b1;
      end else if (move) begin
        busy <= 1'b0;
      end
      if (tok[ENTRIES].valid) begin
        slots_used   <= slots_used_next;
        active_total <= active_total_next;
        pend_valid   <= 1'b1;
      end else if (move) begin
        pend_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok[ENTRIES].valid) begin
      pend_status <= status_next;
      pend_active <= active_total_next;
      pend_fill   <= slots_used_next;
    end
  end

  assign active_ext = 32'(pend_active);
  assign fill_ext   = 32'(pend_fill);
  assign active_rep = (active_ext > 32'd31) ? 5'd31 : active_ext[4:0];
  assign fill_rep   = (fill_ext > 32'd31) ? 5'd31 : fill_ext[4:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      m_axis_tuser <= pend_status;
      m_axis_tdata <= {6'd0, fill_rep, active_rep};
    end
  end

  for (genvar j = 0; j <= ENTRIES; j++) begin : g_cv
    assign chain_valid[j] = tok[j].valid;
  end

  a_count_order: assert property (@(posedge clk) disable iff (rst)
    active_total <= slots_used)
    else $error("active count exceeds fill count");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    $onehot0({chain_valid[ENTRIES:1], pend_valid}))
    else $error("more than one word in flight");

  a_busy_cover: assert property (@(posedge clk) disable iff (rst)
    (pend_valid || chain_valid[ENTRIES:1] != '0) |-> busy)
    else $error("word in flight while input is open");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    slots_used <= CNT_W'(ENTRIES))
    else $error("fill count beyond table size");

endmodule

[dv/tb_fault_code_table_top.sv]
// Testbench for fault_code_table_top: directed and random words checked against a table model.
module tb_fault_code_table_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ENTRIES    = fct_pkg::ENTRIES_DEF;
  localparam int RAND_WORDS = 600;
  localparam int LIMIT      = 400000;

  typedef struct packed {
    fct_pkg::status_t status;
    logic [4:0]       active;
    logic [4:0]       fill;
  } code_result_t;

  typedef struct packed {
    fct_pkg::op_t op;
    logic [15:0]  code;
    bit           typed;
    code_result_t want;
  } opening_row_t;

  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = 16'h0000;
  logic [0:0]  s_axis_tuser  = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  fault_code_table_top #(.ENTRIES(ENTRIES)) dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #2 clk = ~clk;

  // local copy of the table
  bit [15:0] codes_seen [ENTRIES];
  bit        marks      [ENTRIES];
  int        filled = 0;
  int        live   = 0;

  code_result_t pending_results [$];
  int           errors = 0;
  int           cycles = 0;
  int           status_tally [4] = '{0, 0, 0, 0};
  bit           calm = 1'b0;
  int           stall_left = 0;

  opening_row_t opening_words [17] = '{
    '{fct_pkg::OP_CLEAR, 16'h0000, 1'b1, '{fct_pkg::ST_CLEARED, 5'd0, 5'd0}},
    '{fct_pkg::OP_CLEAR, 16'hFFFF, 1'b1, '{fct_pkg::ST_CLEARED, 5'd0, 5'd0}},
    '{fct_pkg::OP_ADD,   16'h0000, 1'b1, '{fct_pkg::ST_ADDED,   5'd1, 5'd1}},
    '{fct_pkg::OP_ADD,   16'hFFFF, 1'b1, '{fct_pkg::ST_ADDED,   5'd2, 5'd2}},
    '{fct_pkg::OP_ADD,   16'hFFFF, 1'b1, '{fct_pkg::ST_DUP,     5'd2, 5'd2}},
    '{fct_pkg::OP_ADD,   16'h0000, 1'b1, '{fct_pkg::ST_DUP,     5'd2, 5'd2}},
    '{fct_pkg::OP_ADD,   16'hA5A5, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_ADD,   16'h5A5A, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_CLEAR, 16'hA5A5, 1'b1, '{fct_pkg::ST_CLEARED, 5'd0, 5'd4}},
    '{fct_pkg::OP_ADD,   16'hFFFF, 1'b1, '{fct_pkg::ST_ADDED,   5'd1, 5'd5}},
    '{fct_pkg::OP_ADD,   16'hFFFF, 1'b1, '{fct_pkg::ST_DUP,     5'd1, 5'd5}},
    '{fct_pkg::OP_ADD,   16'h0000, 1'b1, '{fct_pkg::ST_ADDED,   5'd2, 5'd6}},
    '{fct_pkg::OP_ADD,   16'h8000, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_ADD,   16'h0001, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_ADD,   16'h7FFF, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_ADD,   16'h0001, 1'b0, '{fct_pkg::ST_ADDED,   5'd0, 5'd0}},
    '{fct_pkg::OP_CLEAR, 16'h1234, 1'b1, '{fct_pkg::ST_CLEARED, 5'd0, 5'd9}}
  };

  function automatic code_result_t apply_word(fct_pkg::op_t op, logic [15:0] code);
    code_result_t r;
    bit hit;
    hit = 1'b0;
    if (op == fct_pkg::OP_CLEAR) begin
      foreach (marks[i]) marks[i] = 1'b0;
      live = 0;
      r.status = fct_pkg::ST_CLEARED;
    end else if (filled >= ENTRIES) begin
      r.status = fct_pkg::ST_FULL;
    end else begin
      for (int i = 0; i < filled; i++)
        if (marks[i] && codes_seen[i] == code) hit = 1'b1;
      if (hit) begin
        r.status = fct_pkg::ST_DUP;
      end else begin
        codes_seen[filled] = code;
        marks[filled] = 1'b1;
        filled++;
        live++;
        r.status = fct_pkg::ST_ADDED;
      end
    end
    r.active = (live > 31) ? 5'd31 : 5'(live);
    r.fill   = (filled > 31) ? 5'd31 : 5'(filled);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_word(input fct_pkg::op_t op, input logic [15:0] code,
                           input bit typed, input code_result_t want);
    int gap;
    code_result_t res;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= code;
    do @(posedge clk); while (!s_axis_tready);
    res = apply_word(op, code);
    pending_results.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    code_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report("unexpected word", m_axis_tuser, 0);
      end else begin
        want = pending_results.pop_front();
        if (fct_pkg::status_t'(m_axis_tuser) != want.status)
          report("status", m_axis_tuser, want.status);
        if (m_axis_tdata[4:0] != want.active)
          report("live_cnt", m_axis_tdata[4:0], want.active);
        if (m_axis_tdata[9:5] != want.fill)
          report("fill_count", m_axis_tdata[9:5], want.fill);
        if (m_axis_tdata[15:10] != 6'd0)
          report("tdata pad", m_axis_tdata[15:10], 0);
        status_tally[m_axis_tuser]++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb_fault_code_table_top: errors");
      $finish;
    end
  end

  initial begin
    fct_pkg::op_t op;
    logic [15:0]  code;
    int           r;
    int           idx;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (opening_words[i])
      push_word(opening_words[i].op, opening_words[i].code, opening_words[i].typed,
                opening_words[i].want);

    for (int n = 0; n < RAND_WORDS; n++) begin
      if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      op = ($urandom_range(0, 99) < 8) ? fct_pkg::OP_CLEAR : fct_pkg::OP_ADD;
      r  = $urandom_range(0, 9);
      if (r < 4 && filled > 0) begin
        idx = $urandom_range(0, filled - 1);
        // once full, aim at live codes so full wins over a duplicate
        if (filled >= ENTRIES && live > 0)
          while (!marks[idx]) idx = (idx + 1) % filled;
        code = codes_seen[idx];
      end else if (r < 7) begin
        code = {{13{$urandom_range(0, 1) == 1}}, 3'($urandom_range(0, 7))};
      end else begin
        code = 16'($urandom);
      end
      push_word(op, code, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (ENTRIES + 4) @(posedge clk);

    $display("run covered %0d words in %0d cycles: %0d added, %0d full, %0d duplicate, %0d cleared",
             RAND_WORDS + 17, cycles, status_tally[fct_pkg::ST_ADDED],
             status_tally[fct_pkg::ST_FULL], status_tally[fct_pkg::ST_DUP],
             status_tally[fct_pkg::ST_CLEARED]);
    $display("table ended with %0d of %0d slots filled, %0d live; %0d mismatches",
             filled, ENTRIES, live, errors);
    if (errors == 0) begin
      $display("tb_fault_code_table_top: clean");
    end else begin
      $display("tb_fault_code_table_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/fct_pkg.sv
rtl/fct_cell.sv
rtl/fault_code_table_top.sv
dv/tb_fault_code_table_top.sv
